FILE: hdl/sac_pkg.sv
// Shared constants, command/status types and elaboration helpers for the
// set-associative tag store with timestamp LRU. No dependencies.
package sac_pkg;

  localparam int DEF_MAX_SETS    = 512;
  localparam int DEF_MAX_WAYS    = 8;
  localparam int DEF_STAMP_WIDTH = 32;

  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int CNT_W      = 32;
  localparam int SET_NUM_W  = 9;
  localparam int WAY_NUM_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_OFFSET_BITS = 4'd6;
  localparam logic [CFG_DATA_W-1:0] RST_SET_BITS    = 4'd4;
  localparam logic [CFG_DATA_W-1:0] RST_WAYS_IN_USE = 4'd1;

  typedef struct packed {
    logic capture;
    logic commit;
    logic clear;
  } sac_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_room;
  } sac_sts_t;

  function automatic int floor_log2(input int n);
    int r;
    r = 0;
    while ((64'd1 << (r + 1)) <= 64'(n)) r = r + 1;
    return r;
  endfunction

endpackage

FILE: hdl/sac_req_if.sv
// Request channel: one byte address per transfer.
// Depends on sac_pkg.
interface sac_req_if import sac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

FILE: hdl/sac_rsp_if.sv
// Response channel: lookup result and running counts per transfer.
// Depends on sac_pkg.
interface sac_rsp_if import sac_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [SET_NUM_W-1:0] set_number;
  logic [WAY_NUM_W-1:0] way_used;
  logic [CNT_W-1:0]     access_count;
  logic [CNT_W-1:0]     miss_count;

  modport source (output valid, output hit, output set_number, output way_used,
                  output access_count, output miss_count, input ready);
  modport sink   (input valid, input hit, input set_number, input way_used,
                  input access_count, input miss_count, output ready);
endinterface

FILE: hdl/sac_cfg_if.sv
// Configuration write channel: register index and write data per transfer.
// Depends on sac_pkg.
interface sac_cfg_if import sac_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/sac_ctrl.sv
// Controller: clearing pass after reset, then capture / commit sequencing.
// Depends on sac_pkg.
module sac_ctrl import sac_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  sac_sts_t sts,
  output logic     req_ready,
  output sac_cmd_t cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (sts.out_room) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign req_ready = (state == ST_IDLE);

endmodule

FILE: hdl/sac_dp.sv
// Datapath: config registers, tag/valid/stamp row memories, hit search,
// victim choice, counters and the result register. Depends on sac_pkg.
module sac_dp import sac_pkg::*; #(
  parameter int MAX_SETS    = DEF_MAX_SETS,
  parameter int MAX_WAYS    = DEF_MAX_WAYS,
  parameter int STAMP_WIDTH = DEF_STAMP_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sac_cmd_t              cmd,
  output sac_sts_t              sts,
  input  logic [ADDR_W-1:0]     req_address,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output logic                  rsp_hit,
  output logic [SET_NUM_W-1:0]  rsp_set_number,
  output logic [WAY_NUM_W-1:0]  rsp_way_used,
  output logic [CNT_W-1:0]      rsp_access_count,
  output logic [CNT_W-1:0]      rsp_miss_count
);

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SB_MAX = floor_log2(MAX_SETS);
  localparam int NW_W   = ($clog2(MAX_WAYS + 1) > CFG_DATA_W) ?
                          $clog2(MAX_WAYS + 1) : CFG_DATA_W;

  typedef logic [MAX_WAYS-1:0][TAG_W-1:0]       tag_row_t;
  typedef logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] stamp_row_t;
  typedef logic [MAX_WAYS-1:0]                  valid_row_t;

  tag_row_t   tag_mem   [MAX_SETS];
  stamp_row_t stamp_mem [MAX_SETS];
  valid_row_t valid_mem [MAX_SETS];

  logic [CFG_DATA_W-1:0] offset_bits;
  logic [CFG_DATA_W-1:0] set_bits;
  logic [CFG_DATA_W-1:0] ways_in_use;

  logic [CFG_DATA_W-1:0] sb;
  logic [NW_W-1:0]       ways_ext;
  logic [NW_W-1:0]       nw;
  logic [ADDR_W-1:0]     block;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      set_in;
  logic [TAG_W-1:0]      tag_in;

  logic [SET_W-1:0]      set_q;
  logic [TAG_W-1:0]      tag_q;
  tag_row_t              tag_row;
  stamp_row_t            stamp_row;
  valid_row_t            valid_row;

  logic [MAX_WAYS-1:0]   in_use;
  logic [MAX_WAYS-1:0]   match;
  logic [MAX_WAYS-1:0]   empty;
  logic [MAX_WAYS-1:0]   is_min;
  logic [WAY_W-1:0]      hit_way;
  logic [WAY_W-1:0]      empty_way;
  logic [WAY_W-1:0]      min_way;
  logic [WAY_W-1:0]      way;
  logic                  hit;

  tag_row_t              tag_row_new;
  stamp_row_t            stamp_row_new;
  valid_row_t            valid_row_new;

  logic [STAMP_WIDTH-1:0] stamp_now;
  logic [STAMP_WIDTH-1:0] stamp_new;
  logic [CNT_W-1:0]       access_cnt;
  logic [CNT_W-1:0]       miss_cnt;
  logic [CNT_W-1:0]       access_cnt_next;
  logic [CNT_W-1:0]       miss_cnt_next;
  logic [SET_W-1:0]       clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= RST_OFFSET_BITS;
      set_bits    <= RST_SET_BITS;
      ways_in_use <= RST_WAYS_IN_USE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OFFSET_BITS: offset_bits <= cfg_data;
        REG_SET_BITS:    set_bits    <= cfg_data;
        REG_WAYS_IN_USE: ways_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ways_ext = NW_W'(ways_in_use);
    if (ways_ext == '0) begin
      nw = NW_W'(1);
    end else if (ways_ext > NW_W'(MAX_WAYS)) begin
      nw = NW_W'(MAX_WAYS);
    end else begin
      nw = ways_ext;
    end
  end

  assign sb       = (set_bits > CFG_DATA_W'(SB_MAX)) ? CFG_DATA_W'(SB_MAX) : set_bits;
  assign block    = req_address >> offset_bits;
  assign set_mask = (SET_W'(1) << sb) - SET_W'(1);
  assign set_in   = block[SET_W-1:0] & set_mask;
  assign tag_in   = TAG_W'(block >> sb);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_q     <= set_in;
      tag_q     <= tag_in;
      tag_row   <= tag_mem[set_in];
      stamp_row <= stamp_mem[set_in];
      valid_row <= valid_mem[set_in];
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i] = (NW_W'(i) < nw);
      match[i]  = in_use[i] && valid_row[i] && (tag_row[i] == tag_q);
      empty[i]  = in_use[i] && !valid_row[i];
      is_min[i] = in_use[i];
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (j != i && in_use[j]) begin
          if (j < i) begin
            is_min[i] = is_min[i] && (stamp_row[i] < stamp_row[j]);
          end else begin
            is_min[i] = is_min[i] && (stamp_row[i] <= stamp_row[j]);
          end
        end
      end
    end
  end

  always_comb begin
    hit_way   = '0;
    empty_way = '0;
    min_way   = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (match[i])  hit_way   = WAY_W'(i);
      if (empty[i])  empty_way = WAY_W'(i);
      if (is_min[i]) min_way   = WAY_W'(i);
    end
    hit = |match;
    if (hit) begin
      way = hit_way;
    end else if (|empty) begin
      way = empty_way;
    end else begin
      way = min_way;
    end
  end

  assign stamp_new       = stamp_now + STAMP_WIDTH'(1);
  assign access_cnt_next = access_cnt + CNT_W'(1);
  assign miss_cnt_next   = hit ? miss_cnt : miss_cnt + CNT_W'(1);

  always_comb begin
    tag_row_new        = tag_row;
    valid_row_new      = valid_row;
    stamp_row_new      = stamp_row;
    stamp_row_new[way] = stamp_new;
    if (!hit) begin
      tag_row_new[way]   = tag_q;
      valid_row_new[way] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      tag_mem[set_q]   <= tag_row_new;
      stamp_mem[set_q] <= stamp_row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      valid_mem[clr_idx] <= '0;
    end else if (cmd.commit) begin
      valid_mem[set_q] <= valid_row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear) begin
      clr_idx <= clr_idx + SET_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_now  <= '0;
      access_cnt <= '0;
      miss_cnt   <= '0;
      rsp_valid  <= 1'b0;
    end else if (cmd.commit) begin
      stamp_now  <= stamp_new;
      access_cnt <= access_cnt_next;
      miss_cnt   <= miss_cnt_next;
      rsp_valid  <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_hit          <= hit;
      rsp_set_number   <= SET_NUM_W'(set_q);
      rsp_way_used     <= WAY_NUM_W'(way);
      rsp_access_count <= access_cnt_next;
      rsp_miss_count   <= miss_cnt_next;
    end
  end

  assign sts.clear_last = (clr_idx == SET_W'(MAX_SETS - 1));
  assign sts.out_room   = !rsp_valid || rsp_ready;

endmodule

FILE: hdl/set_assoc_cache_lru_lookup.sv
// Set-associative tag store with timestamp LRU replacement.
// Channels: req (address in), rsp (hit, set, way, counts out), cfg (register
// writes: 0 offset_bits, 1 set_bits, 2 ways_in_use; other indexes ignored).
// Each address is split into offset, set index and tag; all ways of the set
// are read as one row, searched, and the row is written back.
// rsp.valid is registered: the row is read on the req transfer and the result
// is committed from the lookup state once the result register has room. A new
// address is taken only after the previous one is written back to the memories.
// Reset: rst is synchronous. Afterwards the valid memory is cleared one set
// per cycle, all MAX_SETS sets, with req.ready low; cfg writes are taken
// throughout. Counters, stamp counter and cfg registers return to defaults.
// Stall: the result register holds while rsp.ready is low; one further
// address may be taken and looked up, then the block waits until the held
// result is transferred. cfg.ready is always high; write only when idle.
// Depends on sac_pkg, sac_req_if, sac_rsp_if, sac_cfg_if, sac_ctrl, sac_dp.
module set_assoc_cache_lru_lookup import sac_pkg::*; #(
  parameter int MAX_SETS    = DEF_MAX_SETS,
  parameter int MAX_WAYS    = DEF_MAX_WAYS,
  parameter int STAMP_WIDTH = DEF_STAMP_WIDTH
) (
  input logic       clk,
  input logic       rst,
  sac_req_if.sink   req,
  sac_rsp_if.source rsp,
  sac_cfg_if.sink   cfg
);

  sac_cmd_t cmd;
  sac_sts_t sts;
  logic     req_ready;
  logic     rsp_valid;

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;
  assign cfg.ready = 1'b1;

  sac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .sts       (sts),
    .req_ready (req_ready),
    .cmd       (cmd)
  );

  sac_dp #(
    .MAX_SETS    (MAX_SETS),
    .MAX_WAYS    (MAX_WAYS),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .req_address      (req.address),
    .cfg_valid        (cfg.valid),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .rsp_valid        (rsp_valid),
    .rsp_ready        (rsp.ready),
    .rsp_hit          (rsp.hit),
    .rsp_set_number   (rsp.set_number),
    .rsp_way_used     (rsp.way_used),
    .rsp_access_count (rsp.access_count),
    .rsp_miss_count   (rsp.miss_count)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp_valid || rsp.ready))
    else $error("result register overwritten while held");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req_ready) |=> !req_ready)
    else $error("second transfer taken before lookup finished");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !req_ready)
    else $error("request taken during clearing pass");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.commit))
    else $error("result appeared without a commit");

endmodule
